// File: rtl/assert_macros.svh
// assertion helpers for the cache checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// File: rtl/lkc_pkg.sv
package lkc_pkg;
  localparam int Capacity = 64;
  localparam int SlotW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);

  localparam logic [2:0] ST_MISS = 3'd0;
  localparam logic [2:0] ST_HIT = 3'd1;
  localparam logic [2:0] ST_INS = 3'd2;
  localparam logic [2:0] ST_EVICT = 3'd3;
  localparam logic [2:0] ST_DUP = 3'd4;
  localparam logic [2:0] ST_EMPTY = 3'd5;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // link update steps
  localparam logic [3:0] LK_NONE = 4'd0;
  localparam logic [3:0] LK_UNL_OLDER = 4'd1;   // older[nw] = od
  localparam logic [3:0] LK_UNL_NEWER = 4'd2;   // newer[od] = nw
  localparam logic [3:0] LK_TGT_OLDER = 4'd3;   // older[tgt] = head
  localparam logic [3:0] LK_TGT_NEWER = 4'd4;   // newer[tgt] = tail
  localparam logic [3:0] LK_TAIL_OLDER = 4'd5;  // older[tail] = tgt
  localparam logic [3:0] LK_HEAD_NEWER = 4'd6;  // newer[head] = tgt
  localparam logic [3:0] LK_SELF = 4'd7;        // slot 0 links to itself
  localparam logic [3:0] LK_SEL_TGT = 4'd9;     // pick target slot
  localparam logic [3:0] LK_SET_HEAD = 4'd10;   // head = tgt

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // latch request, clear scan index
    logic scan_rd;    // read key at scan index
    logic scan_inc;   // advance scan index
    logic rd_links;   // read links of selected slot
    logic rd_head;    // read newer link of head
    logic wr_entry;   // write key/handle/length at target
    logic [3:0] lnk;  // link update step
    logic done;       // produce result
  } lkc_cmd_t;

  // status back to controller
  typedef struct packed {
    logic scan_end;   // scan index reached entry_count
    logic match;      // registered key compare
    logic is_head;    // found slot is head
    logic empty;      // entry_count zero
    logic full;       // entry_count at capacity
    logic op;
    logic len_zero;
  } lkc_stat_t;
endpackage

// File: rtl/lkc_datapath.sv
module lkc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  lkc_pkg::lkc_cmd_t   cmd,
  output lkc_pkg::lkc_stat_t  stat,
  input  logic                opcode,
  input  logic [63:0]         key,
  input  logic [31:0]         payload_handle,
  input  logic [7:0]          payload_length,
  output logic                strobe,
  output logic [2:0]          status,
  output logic [31:0]         hit_handle,
  output logic [7:0]          hit_length,
  output logic [63:0]         evicted_key
);
  import lkc_pkg::*;

  logic [63:0] key_mem [Capacity];
  logic [31:0] hnd_mem [Capacity];
  logic [7:0]  len_mem [Capacity];
  logic [SlotW-1:0] newer_mem [Capacity];
  logic [SlotW-1:0] older_mem [Capacity];

  logic              r_op;
  logic [63:0]       r_key;
  logic [31:0]       r_hnd;
  logic [7:0]        r_len;
  logic              r_full;
  logic [CountW-1:0] scan;
  logic [CountW-1:0] entry_count;
  logic [SlotW-1:0]  head_slot;
  logic [SlotW-1:0]  found;
  logic [SlotW-1:0]  tgt;
  logic [SlotW-1:0]  nw, od, tail;
  logic [63:0]       rd_key;
  logic              rd_vld;
  logic              match;
  logic [31:0]       rd_hnd;
  logic [7:0]        rd_len;
  logic [SlotW-1:0]  rd_newer, rd_older;
  logic [SlotW-1:0]  lw_addr, lw_data;
  logic              lw_newer, lw_older;

  assign stat.scan_end = (scan == entry_count);
  assign stat.match = match;
  assign stat.is_head = (found == head_slot);
  assign stat.empty = (entry_count == '0);
  assign stat.full = (entry_count == CountW'(Capacity));
  assign stat.op = r_op;
  assign stat.len_zero = (r_len == '0);

  // link write select per step
  always_comb begin
    lw_addr = '0;
    lw_data = '0;
    lw_newer = 1'b0;
    lw_older = 1'b0;
    unique case (cmd.lnk)
      LK_UNL_OLDER: begin lw_addr = nw; lw_data = od; lw_older = 1'b1; end
      LK_UNL_NEWER: begin lw_addr = od; lw_data = nw; lw_newer = 1'b1; end
      LK_TGT_OLDER: begin lw_addr = tgt; lw_data = head_slot; lw_older = 1'b1; end
      LK_TGT_NEWER: begin lw_addr = tgt; lw_data = tail; lw_newer = 1'b1; end
      LK_TAIL_OLDER: begin lw_addr = tail; lw_data = tgt; lw_older = 1'b1; end
      LK_HEAD_NEWER: begin lw_addr = head_slot; lw_data = tgt; lw_newer = 1'b1; end
      LK_SELF: begin
        lw_addr = '0;
        lw_data = '0;
        lw_newer = 1'b1;
        lw_older = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lw_newer) newer_mem[lw_addr] <= lw_data;
    if (lw_older) older_mem[lw_addr] <= lw_data;
    if (cmd.wr_entry) begin
      key_mem[tgt] <= r_key;
      hnd_mem[tgt] <= r_hnd;
      len_mem[tgt] <= r_len;
    end
    // outside the scan the key port reads the target, giving the evicted key
    rd_key <= key_mem[cmd.scan_rd ? scan[SlotW-1:0] : tgt];
    rd_hnd <= hnd_mem[found];
    rd_len <= len_mem[found];
    rd_newer <= newer_mem[cmd.rd_head ? head_slot : found];
    rd_older <= older_mem[found];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      head_slot <= '0;
      scan <= '0;
      rd_vld <= 1'b0;
      match <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.done;
      if (cmd.load) begin
        r_op <= opcode;
        r_key <= key;
        r_hnd <= payload_handle;
        r_len <= payload_length;
        r_full <= (entry_count == CountW'(Capacity));
        scan <= '0;
        match <= 1'b0;
        rd_vld <= 1'b0;
      end else begin
        rd_vld <= cmd.scan_rd;
        if (cmd.scan_inc) scan <= scan + 1'b1;
        // keep the first hit until the next load
        if (rd_vld && !match) begin
          match <= (rd_key == r_key);
          found <= scan[SlotW-1:0] - 1'b1;
        end
      end
      if (cmd.rd_links) begin
        nw <= rd_newer;
        od <= rd_older;
      end
      if (cmd.rd_head) tail <= rd_newer;
      // choose target slot for insert or move
      if (cmd.lnk == LK_SEL_TGT) begin
        if (r_op == OP_LOOKUP) tgt <= found;
        else if (entry_count == '0) tgt <= '0;
        else if (entry_count != CountW'(Capacity)) tgt <= entry_count[SlotW-1:0];
        else tgt <= rd_newer;
      end else if (cmd.lnk == LK_SELF) begin
        tgt <= '0;
      end
      if (cmd.wr_entry) begin
        head_slot <= tgt;
        if (entry_count != CountW'(Capacity)) entry_count <= entry_count + 1'b1;
      end
      if (cmd.lnk == LK_SET_HEAD) head_slot <= tgt;
      if (cmd.done) begin
        status <= ST_MISS;
        hit_handle <= '0;
        hit_length <= '0;
        evicted_key <= '0;
        if (r_op == OP_LOOKUP) begin
          if (match) begin
            status <= ST_HIT;
            hit_handle <= rd_hnd;
            hit_length <= rd_len;
          end
        end else if (match) status <= ST_DUP;
        else if (r_len == '0) status <= ST_EMPTY;
        else if (r_full) begin
          status <= ST_EVICT;
          evicted_key <= rd_key;
        end else status <= ST_INS;
      end
    end
  end
endmodule

// File: rtl/lkc_ctrl.sv
module lkc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lkc_pkg::lkc_stat_t stat,
  output lkc_pkg::lkc_cmd_t  cmd
);
  import lkc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN, S_WAIT1, S_WAIT2, S_CHK, S_HITRD, S_HITLK, S_UN1, S_UN2,
    S_HEADRD, S_HEADLK, S_TGT, S_L3, S_L4, S_L5, S_L6, S_SETH,
    S_EVRD, S_EVWAIT, S_WR, S_FIRST, S_DONE
  } state_t;

  state_t state;
  logic   moving;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      moving <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin state <= S_SCAN; busy <= 1'b1; end
        S_SCAN: if (stat.match) state <= S_CHK;
                else if (stat.scan_end) state <= S_WAIT1;
        S_WAIT1: state <= S_WAIT2;
        S_WAIT2: state <= S_CHK;
        S_CHK: begin
          if (stat.match) begin
            if (stat.op == OP_LOOKUP && !stat.is_head) begin
              moving <= 1'b1;
              state <= S_HITRD;
            end else state <= S_DONE;
          end else if (stat.op == OP_LOOKUP || stat.len_zero) state <= S_DONE;
          else begin
            moving <= 1'b0;
            if (stat.empty) state <= S_FIRST;
            else if (stat.full) state <= S_EVRD;
            else state <= S_HEADRD;
          end
        end
        S_HITRD: state <= S_HITLK;
        S_HITLK: state <= S_UN1;
        S_UN1: state <= S_UN2;
        S_UN2: state <= S_HEADRD;
        S_HEADRD: state <= S_HEADLK;
        S_HEADLK: state <= S_TGT;
        S_TGT: state <= S_L3;
        S_L3: state <= S_L4;
        S_L4: state <= S_L5;
        S_L5: state <= S_L6;
        S_L6: state <= moving ? S_SETH : S_WR;
        S_SETH: state <= S_DONE;
        S_FIRST: state <= S_WR;
        S_EVRD: state <= S_EVWAIT;
        S_EVWAIT: state <= S_WR;
        S_WR: state <= S_DONE;
        S_DONE: begin state <= S_IDLE; busy <= 1'b0; moving <= 1'b0; end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.load = start;
      S_SCAN: begin
        cmd.scan_rd = !stat.scan_end;
        cmd.scan_inc = !stat.scan_end;
      end
      S_HITRD: ;
      S_HITLK: cmd.rd_links = 1'b1;
      S_UN1: cmd.lnk = LK_UNL_OLDER;
      S_UN2: cmd.lnk = LK_UNL_NEWER;
      S_HEADRD: cmd.rd_head = 1'b1;
      S_HEADLK: cmd.rd_head = 1'b1;
      S_TGT: cmd.lnk = LK_SEL_TGT;
      S_L3: cmd.lnk = LK_TGT_OLDER;
      S_L4: cmd.lnk = LK_TGT_NEWER;
      S_L5: cmd.lnk = LK_TAIL_OLDER;
      S_L6: cmd.lnk = LK_HEAD_NEWER;
      S_SETH: cmd.lnk = LK_SET_HEAD;
      S_FIRST: cmd.lnk = LK_SELF;
      S_EVRD: cmd.rd_head = 1'b1;
      S_EVWAIT: cmd.lnk = LK_SEL_TGT;
      S_WR: cmd.wr_entry = 1'b1;
      S_DONE: cmd.done = 1'b1;
      default: ;
    endcase
  end
endmodule

// File: rtl/lru_keyed_cache_core.sv
// the scan reads one key per cycle and stops once the matching slot is found for a duplicate
// or a hit, else it runs over all entry_count keys; a hit that is not most recent is then
// relinked as most recent, a fresh insert becomes the new head and an evicting insert reuses
// the least recent slot
// one transaction at a time: the next is accepted in the strobe cycle
// synchronous active-high reset empties the cache; the receiver cannot stall results
module lru_keyed_cache_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [63:0] key,
  input  logic [31:0] payload_handle,
  input  logic [7:0]  payload_length,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [31:0] hit_handle,
  output logic [7:0]  hit_length,
  output logic [63:0] evicted_key
);
  import lkc_pkg::*;

  lkc_cmd_t  cmd;
  lkc_stat_t stat;

  // sequencer: scan, link splice, write, report
  lkc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  // stores, recency links, scan index and result registers
  lkc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .opcode(opcode), .key(key), .payload_handle(payload_handle),
    .payload_length(payload_length), .strobe(strobe), .status(status),
    .hit_handle(hit_handle), .hit_length(hit_length), .evicted_key(evicted_key)
  );
endmodule

// File: rtl/lkc_checker.sv
`include "assert_macros.svh"
module lkc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        strobe,
  input logic [2:0]  status,
  input logic [31:0] hit_handle,
  input logic [7:0]  hit_length,
  input logic [63:0] evicted_key
);
  import lkc_pkg::*;
  `CHK_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `CHK_NEXT(a_strobe_pulse, clk, rst, strobe, !strobe)
  `CHK_IMPLY(a_status_range, clk, rst, strobe, status <= ST_EMPTY)
  `CHK_IMPLY(a_miss_zero, clk, rst, strobe && status != ST_HIT, {hit_handle, hit_length} == '0)
  `CHK_IMPLY(a_ev_zero, clk, rst, strobe && status != ST_EVICT, evicted_key == '0)
endmodule

bind lru_keyed_cache_core lkc_checker u_chk (.*);

// File: bench/lru_keyed_cache_core_tb.sv
`timescale 1ns / 1ps

module lru_keyed_cache_core_tb;
  import lkc_pkg::*;

  localparam int Cap = Capacity;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        opcode;
  logic [63:0] key;
  logic [31:0] payload_handle;
  logic [7:0]  payload_length;
  logic        strobe;
  logic [2:0]  status;
  logic [31:0] hit_handle;
  logic [7:0]  hit_length;
  logic [63:0] evicted_key;

  lru_keyed_cache_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .key(key), .payload_handle(payload_handle),
    .payload_length(payload_length), .strobe(strobe), .status(status),
    .hit_handle(hit_handle), .hit_length(hit_length), .evicted_key(evicted_key)
  );

  // one expected answer of the cache
  typedef struct packed {
    logic [2:0]  st;
    logic [31:0] hnd;
    logic [7:0]  len;
    logic [63:0] ev;
  } answer_t;

  // shadow copy of the cache contents and recency chain
  logic [63:0]     sh_key [Cap];
  logic [31:0]     sh_hnd [Cap];
  logic [7:0]      sh_len [Cap];
  logic [SlotW-1:0] sh_newer [Cap];
  logic [SlotW-1:0] sh_older [Cap];
  logic [SlotW-1:0] sh_head;
  int              sh_count;

  answer_t pending_answers[$];
  int      mismatches;
  int      n_sent;
  int      n_checked;
  int      n_evicts;
  int      n_hits;
  bit      idle_en;

  // keys recently inserted, so lookups mostly hit
  logic [63:0] key_pool[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // splice slot s in just newer than the head
  function automatic void chain_before_head(int s);
    int tl;
    tl = int'(sh_newer[sh_head]);
    sh_older[s] = sh_head;
    sh_newer[s] = SlotW'(tl);
    sh_older[tl] = SlotW'(s);
    sh_newer[sh_head] = SlotW'(s);
  endfunction

  function automatic int find_slot(logic [63:0] k);
    for (int i = 0; i < sh_count; i++) begin
      if (sh_key[i] == k) return i;
    end
    return -1;
  endfunction

  // compute the answer and update the shadow cache
  function automatic answer_t cache_predict(logic op, logic [63:0] k,
                                            logic [31:0] h, logic [7:0] l);
    answer_t a;
    int s;
    int nw;
    int od;
    a = '0;
    s = find_slot(k);
    if (op == OP_LOOKUP) begin
      a.st = ST_MISS;
      if (s >= 0) begin
        a.st = ST_HIT;
        a.hnd = sh_hnd[s];
        a.len = sh_len[s];
        // a hit on the head leaves the order alone
        if (s != int'(sh_head)) begin
          nw = int'(sh_newer[s]);
          od = int'(sh_older[s]);
          sh_older[nw] = SlotW'(od);
          sh_newer[od] = SlotW'(nw);
          chain_before_head(s);
          sh_head = SlotW'(s);
        end
      end
    end else if (s >= 0) begin
      a.st = ST_DUP;
    end else if (l == 8'd0) begin
      a.st = ST_EMPTY;
    end else begin
      if (sh_count == 0) begin
        s = 0;
        sh_newer[0] = '0;
        sh_older[0] = '0;
        sh_count = 1;
        a.st = ST_INS;
      end else if (sh_count < Cap) begin
        s = sh_count;
        chain_before_head(s);
        sh_count++;
        a.st = ST_INS;
      end else begin
        // full: the least recent slot is reused in place
        s = int'(sh_newer[sh_head]);
        a.ev = sh_key[s];
        a.st = ST_EVICT;
      end
      sh_key[s] = k;
      sh_hnd[s] = h;
      sh_len[s] = l;
      sh_head = SlotW'(s);
    end
    return a;
  endfunction

  task automatic idle_gap();
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // send one transaction and queue its expected answer
  task automatic send_request(logic op, logic [63:0] k, logic [31:0] h, logic [7:0] l);
    idle_gap();
    start <= 1'b1;
    opcode <= op;
    key <= k;
    payload_handle <= h;
    payload_length <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_answers.insert(pending_answers.size(), cache_predict(op, k, h, l));
    n_sent++;
    if (op == OP_INSERT && l != 0) key_pool.insert(key_pool.size(), k);
    if (key_pool.size() > 96) void'(key_pool.pop_front());
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pool_key();
    if (key_pool.size() == 0) return rand_key();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  // checker: every strobe against the oldest expectation
  always @(posedge clk) begin
    answer_t e;
    if (!rst && strobe) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", status);
      end else begin
        e = pending_answers.pop_front();
        n_checked++;
        if (status == ST_EVICT) n_evicts++;
        if (status == ST_HIT) n_hits++;
        if (status !== e.st || hit_handle !== e.hnd || hit_length !== e.len ||
            evicted_key !== e.ev) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d h=%h l=%h ev=%h got st=%0d h=%h l=%h ev=%h",
                     e.st, e.hnd, e.len, e.ev, status, hit_handle, hit_length,
                     evicted_key);
        end
      end
    end
  end

  // empty cache, extremes of every field, duplicate and zero length cases
  task automatic test_directed();
    send_request(OP_LOOKUP, 64'd0, 32'd0, 8'd0);
    send_request(OP_INSERT, 64'd5, 32'hFFFF_FFFF, 8'd0);
    send_request(OP_INSERT, 64'd0, 32'd0, 8'd1);
    send_request(OP_INSERT, '1, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_INSERT, 64'hA5A5_5A5A_0F0F_F0F0, 32'h1234_5678, 8'h80);
    send_request(OP_LOOKUP, '1, '1, '1);
    send_request(OP_LOOKUP, '1, 32'd0, 8'd0);
    send_request(OP_LOOKUP, 64'd0, 32'd0, 8'd0);
    send_request(OP_INSERT, '1, 32'hDEAD_BEEF, 8'd0);
    send_request(OP_INSERT, 64'd0, 32'd7, 8'd7);
    send_request(OP_LOOKUP, 64'd12345, 32'd0, 8'd0);
    send_request(OP_LOOKUP, 64'hA5A5_5A5A_0F0F_F0F0, 32'd0, 8'd0);
    drain();
  endtask

  // fill past capacity so that eviction order is exercised
  task automatic test_fill_evict();
    for (int i = 0; i < Cap + 10; i++) begin
      send_request(OP_INSERT, 64'h1000 + i, $urandom(), 8'($urandom_range(1, 255)));
      if (i % 7 == 0) send_request(OP_LOOKUP, 64'h1000 + i / 2, '0, '0);
    end
  endtask

  // lookups and inserts of known keys, fresh inserts, zero-length inserts and fresh lookups
  task automatic test_random(int n, bit with_idle);
    int r;
    idle_en = with_idle;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 4) send_request(OP_LOOKUP, pool_key(), $urandom(), 8'($urandom()));
      else if (r < 7)
        send_request(OP_INSERT, rand_key(), $urandom(), 8'($urandom_range(1, 255)));
      else if (r < 8) send_request(OP_INSERT, pool_key(), $urandom(), 8'($urandom()));
      else if (r < 9) send_request(OP_INSERT, rand_key(), $urandom(), 8'd0);
      else send_request(OP_LOOKUP, rand_key(), $urandom(), 8'($urandom()));
      // halfway through, the sender holds off until the cache has answered everything
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    opcode = 1'b0;
    key = '0;
    payload_handle = '0;
    payload_length = '0;
    mismatches = 0;
    n_sent = 0;
    n_checked = 0;
    n_evicts = 0;
    n_hits = 0;
    idle_en = 1'b1;
    sh_head = '0;
    sh_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_evict();
    test_random(1100, 1'b1);
    test_random(300, 1'b0);
    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d transactions: %0d hits, %0d evictions", n_checked, n_hits,
             n_evicts);
    $display("lookups, inserts, duplicates, zero lengths and full store replacement");
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
